/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define BBD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same with an explicit clock and active-low reset.
`define BBD_ASSERT_CR(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* design/bbd_pkg.sv */
// ----------------------------------------------------------------------------
// bbd_pkg
// Types, field widths and codes of the block buffer directory.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int unsigned NumSlotsDef = 32;
  localparam int unsigned NumFilesDef = 8;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned FILE_W     = 8;
  localparam int unsigned BLOCK_W    = 20;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned SLOT_OUT_W = 5;
  localparam int unsigned STAMP_W    = 32;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEW    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIRTY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

  // result actions
  localparam logic [ACT_W-1:0] ACT_HIT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FRESH = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WB    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DONE  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FILE_W-1:0]  file_id;
    logic [BLOCK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic [SLOT_OUT_W-1:0] slot;
    logic [FILE_W-1:0]     out_file;
    logic [BLOCK_W-1:0]    out_block;
    logic                  last;
  } res_t;

endpackage

/* design/bbd_ram.sv */
// ----------------------------------------------------------------------------
// bbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/block_buffer_directory.sv */
// Get and mark dirty scan the slot tags; a get miss then scans the file table, claims and
// fills a slot; a new block scans the file table, then the slot tags, and fills the hit slot
// or claims one. Opening a file writes its table entry; a full table first closes the oldest
// file. Close/delete clear the file entry, then drop its slots. One request at a time; scans
// read one-entry-per-cycle; at most one word per cycle, the receiver cannot stall.
// Reset (async, active low) clears all valid/dirty bits, the stamp counter and the FSM.
// ----------------------------------------------------------------------------
// block_buffer_directory
// Fully associative directory of cached disk blocks with an active-file
// table. Tags and stamps live in two RAMs; valid/dirty bits in flops.
// ----------------------------------------------------------------------------
module block_buffer_directory import bbd_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NumSlotsDef,
  parameter int unsigned NUM_FILES = NumFilesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned SW     = $clog2(NUM_SLOTS);
  localparam int unsigned FW     = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int unsigned MAXN   = (NUM_SLOTS > NUM_FILES) ? NUM_SLOTS : NUM_FILES;
  localparam int unsigned CW     = $clog2(MAXN + 1);
  localparam int unsigned SRAM_W = FILE_W + BLOCK_W + STAMP_W;
  localparam int unsigned FRAM_W = FILE_W + STAMP_W;

  // FSM codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SSCAN = 4'd1;  // slot tag lookup
  localparam logic [3:0] S_FSCAN = 4'd2;  // file table lookup (open)
  localparam logic [3:0] S_DROP  = 4'd3;  // drop a file's slots
  localparam logic [3:0] S_FWR   = 4'd4;  // write file table entry
  localparam logic [3:0] S_CLAIM = 4'd5;  // pick free or oldest slot
  localparam logic [3:0] S_FILL  = 4'd6;  // write slot tag
  localparam logic [3:0] S_CSCAN = 4'd7;  // clear file table entry (close/delete)
  localparam logic [3:0] S_DONE  = 4'd8;

  // ---- control state ----
  logic [3:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 dv_q, dv_d;
  logic [NUM_SLOTS-1:0] svalid_q, svalid_d;
  logic [NUM_SLOTS-1:0] sdirty_q, sdirty_d;
  logic [NUM_FILES-1:0] fvalid_q, fvalid_d;
  logic [STAMP_W-1:0]   stamp_q, stamp_d;
  logic                 res_valid_q, res_valid_d;
  logic                 hit_q, hit_d;
  logic                 smin_have_q, smin_have_d;
  logic                 ffound_q, ffound_d;
  logic                 fmin_have_q, fmin_have_d;

  // ---- payload ----
  req_t                 req_q, req_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [SW-1:0]        hit_idx_q, hit_idx_d;
  logic [STAMP_W-1:0]   smin_stamp_q, smin_stamp_d;
  logic [SW-1:0]        smin_idx_q, smin_idx_d;
  logic [FILE_W-1:0]    smin_file_q, smin_file_d;
  logic [BLOCK_W-1:0]   smin_block_q, smin_block_d;
  logic [STAMP_W-1:0]   fmin_stamp_q, fmin_stamp_d;
  logic [FW-1:0]        fmin_idx_q, fmin_idx_d;
  logic [FILE_W-1:0]    fmin_id_q, fmin_id_d;
  logic [FW-1:0]        fpick_q, fpick_d;
  logic [SW-1:0]        spick_q, spick_d;
  logic [FILE_W-1:0]    drop_file_q, drop_file_d;
  logic                 flush_q, flush_d;
  res_t                 res_q, res_d;

  // ---- RAM ports ----
  logic              s_we, f_we;
  logic [SRAM_W-1:0] s_wdata, s_rdata;
  logic [FRAM_W-1:0] f_wdata, f_rdata;
  logic [FILE_W-1:0] rd_sfile, rd_fid;
  logic [BLOCK_W-1:0] rd_sblock;
  logic [STAMP_W-1:0] rd_sstamp, rd_fstamp;

  bbd_ram #(.WIDTH(SRAM_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (spick_q),
    .wdata_i (s_wdata),
    .raddr_i (cnt_q[SW-1:0]),
    .rdata_o (s_rdata)
  );

  bbd_ram #(.WIDTH(FRAM_W), .DEPTH(NUM_FILES)) u_file_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (fpick_q),
    .wdata_i (f_wdata),
    .raddr_i (cnt_q[FW-1:0]),
    .rdata_o (f_rdata)
  );

  assign {rd_sfile, rd_sblock, rd_sstamp} = s_rdata;
  assign {rd_fid, rd_fstamp}              = f_rdata;
  assign s_wdata = {req_q.file_id, req_q.block_number, stamp_q};
  assign f_wdata = {req_q.file_id, stamp_q};

  // lowest free slot / file entry
  logic          sfree_any, ffree_any;
  logic [SW-1:0] sfree_idx;
  logic [FW-1:0] ffree_idx;

  always_comb begin
    sfree_any = ~&svalid_q;
    sfree_idx = '0;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (!svalid_q[k]) sfree_idx = SW'(k);
    end
    ffree_any = ~&fvalid_q;
    ffree_idx = '0;
    for (int k = NUM_FILES - 1; k >= 0; k--) begin
      if (!fvalid_q[k]) ffree_idx = FW'(k);
    end
  end

  // scan sequencing: one read issued per cycle, data lands next cycle on idx_q
  logic          scan_st, issuing, last_data, scan_start;
  logic [CW-1:0] lim;
  logic [SW-1:0] si;
  logic [FW-1:0] fi;
  logic          after_open_claim;

  assign scan_st   = (state_q == S_SSCAN) || (state_q == S_FSCAN) ||
                     (state_q == S_DROP) || (state_q == S_CSCAN);
  assign lim       = ((state_q == S_FSCAN) || (state_q == S_CSCAN)) ?
                     CW'(NUM_FILES) : CW'(NUM_SLOTS);
  assign issuing   = scan_st && (cnt_q < lim);
  assign last_data = dv_q && (idx_q == lim - CW'(1));
  assign si        = idx_q[SW-1:0];
  assign fi        = idx_q[FW-1:0];
  // after a file is open: get goes to claim, new block looks up its tag
  assign after_open_claim = (req_q.kind == KIND_GET);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    dv_d         = 1'b0;
    idx_d        = cnt_q;
    svalid_d     = svalid_q;
    sdirty_d     = sdirty_q;
    fvalid_d     = fvalid_q;
    stamp_d      = stamp_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    smin_have_d  = smin_have_q;
    smin_stamp_d = smin_stamp_q;
    smin_idx_d   = smin_idx_q;
    smin_file_d  = smin_file_q;
    smin_block_d = smin_block_q;
    ffound_d     = ffound_q;
    fmin_have_d  = fmin_have_q;
    fmin_stamp_d = fmin_stamp_q;
    fmin_idx_d   = fmin_idx_q;
    fmin_id_d    = fmin_id_q;
    fpick_d      = fpick_q;
    spick_d      = spick_q;
    drop_file_d  = drop_file_q;
    flush_d      = flush_q;
    req_d        = req_q;
    s_we         = 1'b0;
    f_we         = 1'b0;
    scan_start   = 1'b0;

    if (issuing) begin
      cnt_d = cnt_q + CW'(1);
      dv_d  = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          case (req_i.kind)
            KIND_GET, KIND_DIRTY: begin
              state_d = S_SSCAN;
              scan_start = 1'b1;
            end
            KIND_NEW: begin
              state_d = S_FSCAN;
              scan_start = 1'b1;
            end
            KIND_CLOSE, KIND_DELETE: begin
              state_d = S_CSCAN;
              scan_start = 1'b1;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_SSCAN: begin
        if (dv_q) begin
          if (svalid_q[si] && !hit_q && rd_sfile == req_q.file_id &&
              rd_sblock == req_q.block_number) begin
            hit_d     = 1'b1;
            hit_idx_d = si;
          end
          if (svalid_q[si] && (!smin_have_q || rd_sstamp < smin_stamp_q)) begin
            smin_have_d  = 1'b1;
            smin_stamp_d = rd_sstamp;
            smin_idx_d   = si;
            smin_file_d  = rd_sfile;
            smin_block_d = rd_sblock;
          end
        end
        if (last_data) begin
          case (req_q.kind)
            KIND_GET: begin
              if (hit_d) begin
                res_valid_d = 1'b1;
                res_d = '{ACT_HIT, SLOT_OUT_W'(hit_idx_d), req_q.file_id,
                          req_q.block_number, 1'b1};
                state_d = S_IDLE;
              end else begin
                state_d = S_FSCAN;
                scan_start = 1'b1;
              end
            end
            KIND_NEW: begin
              if (hit_d) begin
                spick_d = hit_idx_d;
                state_d = S_FILL;
              end else begin
                state_d = S_CLAIM;
              end
            end
            default: begin  // mark dirty
              res_valid_d = 1'b1;
              if (hit_d) begin
                sdirty_d[hit_idx_d] = 1'b1;
                res_d = '{ACT_HIT, SLOT_OUT_W'(hit_idx_d), req_q.file_id,
                          req_q.block_number, 1'b1};
              end else begin
                res_d = '{ACT_DONE, '0, req_q.file_id, '0, 1'b1};
              end
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_FSCAN: begin
        if (dv_q) begin
          if (fvalid_q[fi] && rd_fid == req_q.file_id) ffound_d = 1'b1;
          if (fvalid_q[fi] && (!fmin_have_q || rd_fstamp < fmin_stamp_q)) begin
            fmin_have_d  = 1'b1;
            fmin_stamp_d = rd_fstamp;
            fmin_idx_d   = fi;
            fmin_id_d    = rd_fid;
          end
        end
        if (last_data) begin
          if (ffound_d) begin
            state_d = after_open_claim ? S_CLAIM : S_SSCAN;
            scan_start = !after_open_claim;
          end else if (ffree_any) begin
            fpick_d = ffree_idx;
            state_d = S_FWR;
          end else begin
            // table full: close the file opened longest ago
            fpick_d     = fmin_idx_d;
            drop_file_d = fmin_id_d;
            flush_d     = 1'b1;
            state_d     = S_DROP;
            scan_start  = 1'b1;
          end
        end
      end

      S_DROP: begin
        if (dv_q && svalid_q[si] && rd_sfile == drop_file_q) begin
          if (flush_q && sdirty_q[si]) begin
            res_valid_d = 1'b1;
            res_d = '{ACT_WB, SLOT_OUT_W'(si), rd_sfile, rd_sblock, 1'b0};
          end
          svalid_d[si] = 1'b0;
          sdirty_d[si] = 1'b0;
        end
        if (last_data) begin
          state_d = ((req_q.kind == KIND_CLOSE) || (req_q.kind == KIND_DELETE)) ?
                    S_DONE : S_FWR;
        end
      end

      S_FWR: begin
        f_we = 1'b1;
        fvalid_d[fpick_q] = 1'b1;
        state_d = after_open_claim ? S_CLAIM : S_SSCAN;
        scan_start = !after_open_claim;
      end

      S_CLAIM: begin
        if (sfree_any) begin
          spick_d = sfree_idx;
        end else begin
          spick_d = smin_idx_q;
          if (sdirty_q[smin_idx_q]) begin
            res_valid_d = 1'b1;
            res_d = '{ACT_WB, SLOT_OUT_W'(smin_idx_q), smin_file_q, smin_block_q, 1'b0};
          end
        end
        state_d = S_FILL;
      end

      S_FILL: begin
        s_we = 1'b1;
        svalid_d[spick_q] = 1'b1;
        sdirty_d[spick_q] = 1'b0;
        stamp_d = stamp_q + STAMP_W'(1);
        res_valid_d = 1'b1;
        res_d = '{(req_q.kind == KIND_GET) ? ACT_LOAD : ACT_FRESH, SLOT_OUT_W'(spick_q),
                  req_q.file_id, req_q.block_number, 1'b1};
        state_d = S_IDLE;
      end

      S_CSCAN: begin
        if (dv_q && fvalid_q[fi] && rd_fid == req_q.file_id) fvalid_d[fi] = 1'b0;
        if (last_data) begin
          drop_file_d = req_q.file_id;
          flush_d     = (req_q.kind == KIND_CLOSE);
          state_d     = S_DROP;
          scan_start  = 1'b1;
        end
      end

      S_DONE: begin
        res_valid_d = 1'b1;
        res_d = '{ACT_DONE, '0, req_q.file_id, '0, 1'b1};
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    if (scan_start) begin
      cnt_d       = '0;
      dv_d        = 1'b0;
      hit_d       = 1'b0;
      smin_have_d = 1'b0;
      ffound_d    = 1'b0;
      fmin_have_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      dv_q        <= 1'b0;
      svalid_q    <= '0;
      sdirty_q    <= '0;
      fvalid_q    <= '0;
      stamp_q     <= '0;
      res_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      smin_have_q <= 1'b0;
      ffound_q    <= 1'b0;
      fmin_have_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dv_q        <= dv_d;
      svalid_q    <= svalid_d;
      sdirty_q    <= sdirty_d;
      fvalid_q    <= fvalid_d;
      stamp_q     <= stamp_d;
      res_valid_q <= res_valid_d;
      hit_q       <= hit_d;
      smin_have_q <= smin_have_d;
      ffound_q    <= ffound_d;
      fmin_have_q <= fmin_have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    idx_q        <= idx_d;
    hit_idx_q    <= hit_idx_d;
    smin_stamp_q <= smin_stamp_d;
    smin_idx_q   <= smin_idx_d;
    smin_file_q  <= smin_file_d;
    smin_block_q <= smin_block_d;
    fmin_stamp_q <= fmin_stamp_d;
    fmin_idx_q   <= fmin_idx_d;
    fmin_id_q    <= fmin_id_d;
    fpick_q      <= fpick_d;
    spick_q      <= spick_d;
    drop_file_q  <= drop_file_d;
    flush_q      <= flush_d;
    res_q        <= res_d;
  end

  // busy drops with the final word, so a new request may start during its strobe
  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* design/bbd_checker.sv */
// ----------------------------------------------------------------------------
// bbd_checker
// Port-level checks of the block buffer directory, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbd_checker import bbd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic res_valid_o,
  input res_t res_o
);

  // accepted request keeps the block busy
  `BBD_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted request did not raise busy")
  // a writeback is never the final word and comes while still busy
  `BBD_ASSERT(a_wb_busy, res_valid_o && !res_o.last |-> busy, "non-final word while idle")
  // the final word coincides with the block going idle
  `BBD_ASSERT(a_last_idle, res_valid_o && res_o.last |-> !busy, "final word while busy")
  // busy falls only with a final word
  `BBD_ASSERT(a_fall_last, $fell(busy) |-> res_valid_o && res_o.last, "busy fell without final word")

endmodule

bind block_buffer_directory bbd_checker u_bbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

/* dv/tb_block_buffer_directory.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_buffer_directory
// Self-checking bench for the block buffer directory: a directed table of
// requests, then random request streams over a small pool of files and
// blocks, checked word by word against a behavioral directory model.
// ----------------------------------------------------------------------------
module tb_block_buffer_directory;
  import bbd_pkg::*;

  localparam int unsigned NSLOT = NumSlotsDef;
  localparam int unsigned NFILE = NumFilesDef;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  block_buffer_directory u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // Directory model state
  bit                 dir_valid [NSLOT];
  logic [FILE_W-1:0]  dir_file  [NSLOT];
  logic [BLOCK_W-1:0] dir_block [NSLOT];
  bit                 dir_dirty [NSLOT];
  logic [STAMP_W-1:0] dir_stamp [NSLOT];
  logic [STAMP_W-1:0] load_count;
  bit                 ftab_valid [NFILE];
  logic [FILE_W-1:0]  ftab_id    [NFILE];
  logic [STAMP_W-1:0] ftab_stamp [NFILE];

  res_t pending_words[$];
  int   n_err;
  int   n_words;
  int   n_wb;

  function automatic void push_word(logic [ACT_W-1:0] act, int s, logic [FILE_W-1:0] f,
                                    logic [BLOCK_W-1:0] b, logic lst);
    res_t r;
    r.action    = act;
    r.slot      = s[SLOT_OUT_W-1:0];
    r.out_file  = f;
    r.out_block = b;
    r.last      = lst;
    pending_words.push_back(r);
  endfunction

  function automatic void drop_blocks(logic [FILE_W-1:0] f, bit flush);
    for (int i = 0; i < NSLOT; i++) begin
      if (dir_valid[i] && dir_file[i] == f) begin
        if (flush && dir_dirty[i]) push_word(ACT_WB, i, dir_file[i], dir_block[i], 1'b0);
        dir_valid[i] = 0;
        dir_dirty[i] = 0;
      end
    end
    for (int i = 0; i < NFILE; i++)
      if (ftab_valid[i] && ftab_id[i] == f) ftab_valid[i] = 0;
  endfunction

  function automatic int lookup(logic [FILE_W-1:0] f, logic [BLOCK_W-1:0] b);
    for (int i = 0; i < NSLOT; i++)
      if (dir_valid[i] && dir_file[i] == f && dir_block[i] == b) return i;
    return -1;
  endfunction

  // Activate a file; a full table closes the file opened longest ago.
  function automatic void activate(logic [FILE_W-1:0] f);
    int pick;
    pick = -1;
    for (int i = 0; i < NFILE; i++)
      if (ftab_valid[i] && ftab_id[i] == f) return;
    for (int i = 0; i < NFILE; i++)
      if (pick < 0 && !ftab_valid[i]) pick = i;
    if (pick < 0) begin
      pick = 0;
      for (int i = 1; i < NFILE; i++)
        if (ftab_stamp[i] < ftab_stamp[pick]) pick = i;
      drop_blocks(ftab_id[pick], 1'b1);
    end
    ftab_valid[pick] = 1;
    ftab_id[pick]    = f;
    ftab_stamp[pick] = load_count;
  endfunction

  // Lowest free slot, else FIFO victim (written back if dirty).
  function automatic int victim();
    int pick;
    pick = -1;
    for (int i = 0; i < NSLOT; i++)
      if (pick < 0 && !dir_valid[i]) pick = i;
    if (pick < 0) begin
      pick = 0;
      for (int i = 1; i < NSLOT; i++)
        if (dir_stamp[i] < dir_stamp[pick]) pick = i;
      if (dir_dirty[pick]) push_word(ACT_WB, pick, dir_file[pick], dir_block[pick], 1'b0);
    end
    return pick;
  endfunction

  function automatic void fill(int s, logic [FILE_W-1:0] f, logic [BLOCK_W-1:0] b);
    dir_valid[s] = 1;
    dir_file[s]  = f;
    dir_block[s] = b;
    dir_dirty[s] = 0;
    dir_stamp[s] = load_count;
    load_count++;
  endfunction

  function automatic void predict_request(req_t rq);
    int s;
    case (rq.kind)
      KIND_GET: begin
        s = lookup(rq.file_id, rq.block_number);
        if (s >= 0) begin
          push_word(ACT_HIT, s, rq.file_id, rq.block_number, 1'b1);
        end else begin
          activate(rq.file_id);
          s = victim();
          fill(s, rq.file_id, rq.block_number);
          push_word(ACT_LOAD, s, rq.file_id, rq.block_number, 1'b1);
        end
      end
      KIND_NEW: begin
        activate(rq.file_id);
        s = lookup(rq.file_id, rq.block_number);
        if (s < 0) s = victim();
        fill(s, rq.file_id, rq.block_number);
        push_word(ACT_FRESH, s, rq.file_id, rq.block_number, 1'b1);
      end
      KIND_DIRTY: begin
        s = lookup(rq.file_id, rq.block_number);
        if (s < 0) begin
          push_word(ACT_DONE, 0, rq.file_id, '0, 1'b1);
        end else begin
          dir_dirty[s] = 1;
          push_word(ACT_HIT, s, rq.file_id, rq.block_number, 1'b1);
        end
      end
      KIND_CLOSE: begin
        drop_blocks(rq.file_id, 1'b1);
        push_word(ACT_DONE, 0, rq.file_id, '0, 1'b1);
      end
      KIND_DELETE: begin
        drop_blocks(rq.file_id, 1'b0);
        push_word(ACT_DONE, 0, rq.file_id, '0, 1'b1);
      end
      default: push_word(ACT_DONE, 0, rq.file_id, '0, 1'b1);
    endcase
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result checker: sampled at the rising edge, one word per strobe.
  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni && res_valid_o) begin
      n_words++;
      if (res_o.action == ACT_WB) n_wb++;
      if (pending_words.size() == 0) begin
        $error("unexpected result word %h", res_o);
        n_err++;
      end else begin
        w = pending_words.pop_front();
        if (res_o.action !== w.action) begin
          $error("action exp %0d got %0d", w.action, res_o.action); n_err++;
        end
        if (res_o.slot !== w.slot) begin
          $error("slot exp %0d got %0d", w.slot, res_o.slot); n_err++;
        end
        if (res_o.out_file !== w.out_file) begin
          $error("out_file exp %0d got %0d", w.out_file, res_o.out_file); n_err++;
        end
        if (res_o.out_block !== w.out_block) begin
          $error("out_block exp %0d got %0d", w.out_block, res_o.out_block); n_err++;
        end
        if (res_o.last !== w.last) begin
          $error("last exp %0d got %0d", w.last, res_o.last); n_err++;
        end
      end
    end
  end

  // Issue one request at the falling edge and hold it until accepted.
  // Directed rows may carry a hand-typed final word to cross-check the model.
  // Returns at the next falling edge after start drops, so the next drive lands on a new edge.
  task automatic send_request(req_t rq, bit chk, res_t hand);
    predict_request(rq);
    if (chk && pending_words[$] !== hand) begin
      $error("table word exp %h model %h", hand, pending_words[$]);
      n_err++;
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    start <= 1'b0;
    req_i <= '0;
    @(negedge clk_i);
  endtask

  task automatic idle_burst(bit allow);
    if (allow && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  typedef struct {
    req_t rq;
    bit   chk;
    res_t hand;
  } row_t;

  function automatic row_t mk(logic [KIND_W-1:0] k, logic [FILE_W-1:0] f,
                              logic [BLOCK_W-1:0] b, bit chk = 0,
                              logic [ACT_W-1:0] a = '0, int s = 0);
    row_t r;
    r.rq.kind         = k;
    r.rq.file_id      = f;
    r.rq.block_number = b;
    r.chk             = chk;
    r.hand.action     = a;
    r.hand.slot       = s[SLOT_OUT_W-1:0];
    r.hand.out_file   = f;
    r.hand.out_block  = (a == ACT_DONE) ? '0 : b;
    r.hand.last       = 1'b1;
    return r;
  endfunction

  initial begin
    row_t tbl[$];
    req_t rq;
    int   pick;
    logic [FILE_W-1:0] fpool[6];

    n_err = 0; n_words = 0; n_wb = 0;
    load_count = '0;
    foreach (dir_valid[i]) begin
      dir_valid[i] = 0; dir_dirty[i] = 0;
    end
    foreach (ftab_valid[i]) ftab_valid[i] = 0;
    start  = 1'b0;
    req_i  = '0;
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, every kind, hit/miss/dirty/close/delete paths.
    tbl.push_back(mk(KIND_DIRTY, 8'd0, 20'd0, 1, ACT_DONE));
    tbl.push_back(mk(KIND_GET, 8'd0, 20'd0, 1, ACT_LOAD, 0));
    tbl.push_back(mk(KIND_GET, 8'd0, 20'd0, 1, ACT_HIT, 0));
    tbl.push_back(mk(KIND_NEW, 8'hFF, 20'hFFFFF, 1, ACT_FRESH, 1));
    tbl.push_back(mk(KIND_DIRTY, 8'hFF, 20'hFFFFF, 1, ACT_HIT, 1));
    tbl.push_back(mk(KIND_NEW, 8'hFF, 20'hFFFFF, 1, ACT_FRESH, 1));
    tbl.push_back(mk(KIND_DIRTY, 8'hFF, 20'hFFFFF));
    tbl.push_back(mk(KIND_GET, 8'hAA, 20'h55555));
    tbl.push_back(mk(KIND_DIRTY, 8'h0, 20'h0));
    tbl.push_back(mk(KIND_CLOSE, 8'hFF, 20'hFFFFF));
    tbl.push_back(mk(KIND_CLOSE, 8'h77, 20'h0, 1, ACT_DONE));
    tbl.push_back(mk(KIND_DELETE, 8'h0, 20'h0));
    tbl.push_back(mk(KIND_DELETE, 8'h33, 20'h1, 1, ACT_DONE));
    tbl.push_back(mk(3'd5, 8'h12, 20'h3, 1, ACT_DONE));
    tbl.push_back(mk(3'd7, 8'hFF, 20'hFFFFF, 1, ACT_DONE));
    // Nine distinct files overflow the file table and close the oldest.
    for (int i = 1; i <= 9; i++) tbl.push_back(mk(KIND_GET, 8'(i), 20'(i)));
    foreach (tbl[i]) begin
      send_request(tbl[i].rq, tbl[i].chk, tbl[i].hand);
      idle_burst(1);
    end
    // Hold off until everything has drained, at least once.
    drain();

    // Random: mostly a small pool of files and blocks so hits, FIFO
    // evictions and file-table overflow all happen; some noise on top.
    for (int i = 0; i < 136; i++) begin
      if (i % 40 == 0)
        foreach (fpool[j]) fpool[j] = 8'($urandom);
      pick = $urandom_range(0, 99);
      rq.file_id      = fpool[$urandom_range(0, 5)];
      rq.block_number = 20'($urandom_range(0, 11));
      if (pick < 40)      rq.kind = KIND_GET;
      else if (pick < 60) rq.kind = KIND_NEW;
      else if (pick < 80) rq.kind = KIND_DIRTY;
      else if (pick < 87) rq.kind = KIND_CLOSE;
      else if (pick < 92) rq.kind = KIND_DELETE;
      else begin
        rq.kind         = 3'($urandom);
        rq.file_id      = 8'($urandom);
        rq.block_number = 20'($urandom);
      end
      send_request(rq, 0, '0);
      idle_burst(i < 110);
    end

    drain();
    repeat (3 * (NSLOT + NFILE + 10)) @(negedge clk_i);
    $display("Ran directed and 136 random requests over all kinds; %0d words, %0d writebacks.",
             n_words, n_wb);
    if (n_err == 0 && pending_words.size() == 0)
      $display("tb_block_buffer_directory OK");
    else
      $display("tb_block_buffer_directory NOT OK");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb_block_buffer_directory NOT OK");
    $finish;
  end

endmodule
